// ----- rtl/cftm_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cftm_pkg
// Shared constants, state encoding and control bundles for the cron field
// time matcher.
// ============================================================================
package cftm_pkg;

    // Width of the stored decimal numbers; numbers saturate at all ones.
    localparam int VALUE_WIDTH = 8;
    localparam int TIME_W      = 6;
    localparam int CH_W        = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // Dividend of the step test is t + 1 or t - a + 1, at most 64.
    localparam int DIV_W = TIME_W + 1;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int ACC_W = VALUE_WIDTH + 4;

    localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } cftm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_char;
        logic div_start;
        logic div_step;
        logic commit;
        logic use_div;
        logic emit;
    } cftm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic judge_in;
        logic last;
        logic need_div;
        logic div_done;
        logic out_free;
    } cftm_sts_t;

endpackage

// ----- rtl/cftm_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cftm_ctrl
// Sequencer: accepts characters, runs term evaluation and the step divider,
// and hands the field result to the output register.
// ============================================================================
module cftm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cftm_pkg::cftm_sts_t sts,
    output cftm_pkg::cftm_cmd_t cmd
);
    import cftm_pkg::*;

    cftm_state_t state_reg;
    cftm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_char = 1'b1;
                    if (sts.judge_in) begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (sts.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = sts.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.commit  = 1'b1;
                    cmd.use_div = 1'b1;
                    state_next  = sts.last ? ST_EMIT : ST_IDLE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/cftm_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cftm_datapath
// Number history, term flags, term comparison, bit-serial remainder unit
// and the result register.
// ============================================================================
module cftm_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [cftm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic [cftm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  cftm_pkg::cftm_cmd_t                cmd,
    output cftm_pkg::cftm_sts_t                sts
);
    import cftm_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] NUM_MAX = '1;

    logic [VALUE_WIDTH-1:0] hist_reg [3];
    logic [VALUE_WIDTH-1:0] hist_next [3];
    logic [1:0]             seen_reg, seen_next;
    logic                   digit_reg, digit_next;
    logic                   star_reg, star_next;
    logic                   dash_reg, dash_next;
    logic                   slash_reg, slash_next;
    logic [1:0]             sep_reg, sep_next;
    logic                   match_reg, match_next;
    logic [TIME_W-1:0]      t_reg, t_next;
    logic                   last_reg, last_next;
    logic [DIV_W-1:0]       dvd_reg, dvd_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   mvalid_reg, mvalid_next;
    logic                   mdata_reg, mdata_next;

    logic [CH_W-1:0]        ch;
    logic                   is_digit;
    logic [ACC_W-1:0]       acc;
    logic [VALUE_WIDTH-1:0] acc_sat;
    logic [VALUE_WIDTH-1:0] a, b, n, t_ext;
    logic                   direct_ok;
    logic                   need_div;
    logic [DIV_W-1:0]       dvd_in;
    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   rem_diff;
    logic                   term_ok;

    assign ch       = s_tdata[CH_W-1:0];
    assign is_digit = ch inside {[CH_ZERO:CH_NINE]};

    // Decimal accumulate: h0 * 10 + digit, saturating.
    assign acc = ({4'd0, hist_reg[0]} << 3) + ({4'd0, hist_reg[0]} << 1)
               + ACC_W'(ch[3:0]);
    assign acc_sat = (acc > ACC_W'(NUM_MAX)) ? NUM_MAX : acc[VALUE_WIDTH-1:0];

    assign n     = hist_reg[0];
    assign b     = hist_reg[1];
    assign a     = hist_reg[2];
    assign t_ext = VALUE_WIDTH'(t_reg);

    // Term classification from the flags left by the judging character.
    always_comb begin
        direct_ok = 1'b0;
        need_div  = 1'b0;
        dvd_in    = {1'b0, t_reg} + DIV_W'(1);
        case (sep_reg)
            2'd0: begin
                direct_ok = star_reg || (seen_reg != 2'd0 && n == t_ext);
            end
            2'd1: begin
                if (dash_reg) begin
                    direct_ok = seen_reg >= 2'd2 && b <= t_ext && t_ext <= n;
                end else if (star_reg && slash_reg) begin
                    need_div = seen_reg != 2'd0 && n != '0;
                end
            end
            2'd2: begin
                if (dash_reg && slash_reg && seen_reg == 2'd3 && n != '0
                    && a <= t_ext && t_ext <= b) begin
                    need_div = 1'b1;
                    dvd_in   = {1'b0, t_reg} - DIV_W'(a) + DIV_W'(1);
                end
            end
            default: begin
                direct_ok = 1'b0;
            end
        endcase
    end

    // One restoring division step per cycle; only the remainder is kept.
    assign rem_sh   = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, n};
    assign term_ok  = cmd.use_div ? (rem_reg == '0) : direct_ok;

    always_comb begin
        hist_next   = hist_reg;
        seen_next   = seen_reg;
        digit_next  = digit_reg;
        star_next   = star_reg;
        dash_next   = dash_reg;
        slash_next  = slash_reg;
        sep_next    = sep_reg;
        match_next  = match_reg;
        t_next      = t_reg;
        last_next   = last_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (cmd.load_char) begin
            t_next    = s_tdata[CH_W +: TIME_W];
            last_next = s_tlast;
            if (is_digit) begin
                if (digit_reg) begin
                    hist_next[0] = acc_sat;
                end else begin
                    hist_next[2] = hist_reg[1];
                    hist_next[1] = hist_reg[0];
                    hist_next[0] = VALUE_WIDTH'(ch[3:0]);
                    if (seen_reg != 2'd3) begin
                        seen_next = seen_reg + 2'd1;
                    end
                end
                digit_next = 1'b1;
            end else if (ch == CH_STAR) begin
                star_next  = 1'b1;
                digit_next = 1'b0;
            end else if (ch == CH_DASH || ch == CH_SLASH) begin
                if (ch == CH_DASH) begin
                    dash_next = 1'b1;
                end else begin
                    slash_next = 1'b1;
                end
                if (sep_reg != 2'd3) begin
                    sep_next = sep_reg + 2'd1;
                end
                digit_next = 1'b0;
            end
        end

        if (cmd.div_start) begin
            dvd_next = dvd_in;
            rem_next = '0;
            cnt_next = CNT_W'(DIV_W);
        end

        if (cmd.div_step) begin
            dvd_next = dvd_reg << 1;
            rem_next = rem_diff[VALUE_WIDTH] ? rem_sh[VALUE_WIDTH-1:0]
                                             : rem_diff[VALUE_WIDTH-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (cmd.commit) begin
            match_next = match_reg | term_ok;
            star_next  = 1'b0;
            dash_next  = 1'b0;
            slash_next = 1'b0;
            sep_next   = 2'd0;
            digit_next = 1'b0;
        end

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        if (cmd.emit) begin
            mvalid_next  = 1'b1;
            mdata_next   = match_reg;
            hist_next[0] = '0;
            hist_next[1] = '0;
            hist_next[2] = '0;
            seen_next    = 2'd0;
            match_next   = 1'b0;
            last_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            hist_reg[2] <= '0;
            seen_reg    <= 2'd0;
            digit_reg   <= 1'b0;
            star_reg    <= 1'b0;
            dash_reg    <= 1'b0;
            slash_reg   <= 1'b0;
            sep_reg     <= 2'd0;
            match_reg   <= 1'b0;
            last_reg    <= 1'b0;
            cnt_reg     <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            hist_reg    <= hist_next;
            seen_reg    <= seen_next;
            digit_reg   <= digit_next;
            star_reg    <= star_next;
            dash_reg    <= dash_next;
            slash_reg   <= slash_next;
            sep_reg     <= sep_next;
            match_reg   <= match_next;
            last_reg    <= last_next;
            cnt_reg     <= cnt_next;
            mvalid_reg  <= mvalid_next;
        end
        t_reg     <= t_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        mdata_reg <= mdata_next;
    end

    assign sts.judge_in = (ch == CH_COMMA) || s_tlast;
    assign sts.last     = last_reg;
    assign sts.need_div = need_div;
    assign sts.div_done = cnt_reg == '0;
    assign sts.out_free = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, mdata_reg};

endmodule

// ----- rtl/cron_field_time_matcher.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cron_field_time_matcher
// Matches one cron time field, streamed one character per transaction,
// against a time value.
// ============================================================================
// Usage: the slave channel carries one character of the field per
// transaction together with the time value; s_tlast marks the field's final
// character. Terms are comma separated: a number, a star, a range a-b,
// a step */n or a stepped range a-b/n. The master channel returns exactly
// one transaction per field, after the character with s_tlast, whose bit 0
// is 1 when any term of the field matched the time value.
// Sequencing: an ordinary character (digit, star, dash, slash, ignored
// character) is taken in the idle state. A comma or final character adds a
// term evaluation state, then a divide state when the term carries a step,
// since the remainder is found by a bit-serial divider, one dividend bit per
// cycle over seven bits. Input is held off while a term is judged. The
// final character then loads the result register in the emit state, which
// waits while the previous result is still held; input stays held off.
// Reset (aresetn low, synchronous) clears the numbers, flags and match state and
// empties the result register. When the receiver stalls, the result holds in
// the output register and the next field's characters are still accepted;
// only a second field end waits until the held result has been taken.
// ============================================================================
module cron_field_time_matcher (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: [7:0] ch, [13:8] time_value, [15:14] zero.
    input  logic [cftm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [0] matched, [7:1] zero.
    output logic [cftm_pkg::M_TDATA_W-1:0]     m_tdata
);
    import cftm_pkg::*;

    cftm_cmd_t cmd;
    cftm_sts_t sts;

    // The controller sequences each character and each term judgement.
    cftm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the numbers, flags, divider and result register.
    cftm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ----- rtl/cftm_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cftm_checker
// Port-level checks for the cron field time matcher.
// ============================================================================
module cftm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [cftm_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cftm_pkg::M_TDATA_W-1:0] m_tdata
);
    import cftm_pkg::*;

    // A held result keeps its value until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // After the field's final character the block is busy judging.
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready right after field end");

    // A new result is only loaded while input is held off.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a field end");

    // Padding bits of the result are zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
        else $error("result padding not zero");

endmodule

bind cron_field_time_matcher cftm_checker u_cftm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/cron_field_time_matcher_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cron_field_time_matcher_checker
// Watches both channels of the cron field matcher, predicts the match result
// of every field from the accepted characters and compares each result
// transaction with the oldest prediction.
// ============================================================================
module cron_field_time_matcher_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // s_tdata: [7:0] ch, [13:8] time_value, [15:14] zero.
    input  logic [cftm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: [0] matched, [7:1] zero.
    input  logic [cftm_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             pending_results
);
    import cftm_pkg::*;

    localparam int unsigned NUM_MAX = (1 << VALUE_WIDTH) - 1;

    // Parser state of the field being received.
    logic [VALUE_WIDTH-1:0] num_hist [3];
    int unsigned            nums_seen;
    logic                   in_number;
    logic                   star_seen;
    logic                   dash_seen;
    logic                   slash_seen;
    int unsigned            sep_count;
    logic                   field_hit;

    logic [M_TDATA_W-1:0]   expected_match_q [$];
    logic [M_TDATA_W-1:0]   want;
    int                     mismatch_total = 0;
    int                     outstanding    = 0;

    assign fail_count      = mismatch_total;
    assign pending_results = outstanding;

    task automatic clear_term_state();
        star_seen  = 1'b0;
        dash_seen  = 1'b0;
        slash_seen = 1'b0;
        sep_count  = 0;
        in_number  = 1'b0;
    endtask

    task automatic clear_field_state();
        num_hist[0] = '0;
        num_hist[1] = '0;
        num_hist[2] = '0;
        nums_seen   = 0;
        field_hit   = 1'b0;
        clear_term_state();
    endtask

    function automatic logic judge_cron_term(input logic [TIME_W-1:0] tv);
        int unsigned lo;
        int unsigned hi;
        int unsigned newest;
        int unsigned t;
        logic        verdict;
        lo      = 32'(num_hist[2]);
        hi      = 32'(num_hist[1]);
        newest  = 32'(num_hist[0]);
        t       = 32'(tv);
        verdict = 1'b0;
        if (sep_count == 0) begin
            verdict = star_seen || (nums_seen >= 1 && newest == t);
        end else if (sep_count == 1) begin
            if (dash_seen) begin
                verdict = nums_seen >= 2 && hi <= t && t <= newest;
            end else if (star_seen && slash_seen) begin
                verdict = nums_seen >= 1 && newest != 0 && ((t + 1) % newest) == 0;
            end
        end else if (sep_count == 2 && dash_seen && slash_seen) begin
            // Stepped range: lo-hi/newest.
            if (nums_seen >= 3 && newest != 0 && lo <= t && t <= hi) begin
                verdict = ((t - lo + 1) % newest) == 0;
            end
        end
        return verdict;
    endfunction

    task automatic predict_field_char(input logic [CH_W-1:0] ch,
                                      input logic [TIME_W-1:0] tv,
                                      input logic lst);
        int unsigned digit;
        int unsigned grown;
        logic        is_comma;
        is_comma = 1'b0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            digit = 32'(ch - CH_ZERO);
            if (in_number) begin
                grown       = 32'(num_hist[0]) * 10 + digit;
                num_hist[0] = (grown > NUM_MAX) ? VALUE_WIDTH'(NUM_MAX)
                                                : VALUE_WIDTH'(grown);
            end else begin
                num_hist[2] = num_hist[1];
                num_hist[1] = num_hist[0];
                num_hist[0] = VALUE_WIDTH'(digit);
                if (nums_seen < 3) nums_seen++;
            end
            in_number = 1'b1;
        end else if (ch == CH_STAR) begin
            star_seen = 1'b1;
            in_number = 1'b0;
        end else if (ch == CH_DASH) begin
            dash_seen = 1'b1;
            if (sep_count < 3) sep_count++;
            in_number = 1'b0;
        end else if (ch == CH_SLASH) begin
            slash_seen = 1'b1;
            if (sep_count < 3) sep_count++;
            in_number = 1'b0;
        end else if (ch == CH_COMMA) begin
            is_comma = 1'b1;
        end
        // Any other character leaves the state alone.

        if (is_comma || lst) begin
            if (judge_cron_term(tv)) field_hit = 1'b1;
            clear_term_state();
        end
        if (lst) begin
            expected_match_q.push_back({{(M_TDATA_W-1){1'b0}}, field_hit});
            clear_field_state();
        end
    endtask

    initial clear_field_state();

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_field_state();
            expected_match_q.delete();
        end else begin
            // Results are retired before the new character is parsed, since a
            // result can never belong to a character accepted on the same edge.
            if (m_tvalid && m_tready) begin
                if (expected_match_q.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %0h",
                             $time, m_tdata);
                    mismatch_total <= mismatch_total + 1;
                end else begin
                    want = expected_match_q.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: matched result wrong, expected %0h, actual %0h",
                                 $time, want, m_tdata);
                        mismatch_total <= mismatch_total + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_field_char(s_tdata[CH_W-1:0], s_tdata[CH_W +: TIME_W], s_tlast);
            end
        end
        outstanding <= expected_match_q.size();
    end

endmodule

// ----- test/cron_field_time_matcher_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cron_field_time_matcher_tb
// Streams cron time fields into the matcher one character per transaction and
// lets a separate checker predict and compare the per-field match results.
// A short directed set covers stars, plain numbers, ranges, steps, stepped
// ranges, zero steps, saturation, ignored characters and a trailing comma;
// random fields of well-formed terms mixed with noise and broken terms follow,
// with random idle gaps on the input side and random stalls on the output.
// ============================================================================
module cron_field_time_matcher_tb;
    import cftm_pkg::*;

    // Number of random characters to send after the directed part.
    localparam int RANDOM_ITEMS = 1000;
    // Watchdog: far beyond the slowest legal run with the longest gaps.
    localparam int CYCLE_LIMIT  = 400000;
    // A stepped term is the slowest to its result; wait well past it.
    localparam int TAIL_CYCLES  = 40;

    typedef enum int {
        TERM_NUMBER,
        TERM_STAR,
        TERM_RANGE,
        TERM_STEP,
        TERM_RANGE_STEP,
        TERM_BROKEN
    } term_kind_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata: [7:0] ch, [13:8] time_value, [15:14] zero.
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata: [0] matched, [7:1] zero.
    logic [M_TDATA_W-1:0] m_tdata;

    int                   fail_count;
    int                   pending_results;

    // When set, neither side inserts idle cycles.
    logic                 quiet      = 1'b0;
    int                   stall_left = 0;
    int                   cycle_count = 0;
    int                   items_sent = 0;

    // Characters of the field being assembled.
    logic [CH_W-1:0]      field_buf [$];

    // 10 ns clock, high then low.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cron_field_time_matcher DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cron_field_time_matcher_checker field_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The receiver drops m_tready for random stretches unless quiet is set.
    // A stall may start on any cycle, so it lands on every phase of the
    // block's evaluation and divide sequence.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One character transaction: an optional idle gap first, then hold valid
    // until the block takes it. Valid is only lowered when a gap follows, so
    // back-to-back transactions keep it high without a glitch.
    task automatic send_item(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] tv,
                             input logic lst);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-CH_W-TIME_W){1'b0}}, tv, ch};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Sends the assembled field with tlast on its final character. With vary
    // set, each character carries its own time value, which checks that the
    // value given with the judging character is the one used.
    task automatic send_field(input logic [TIME_W-1:0] tv, input bit vary);
        int k;
        for (k = 0; k < field_buf.size(); k++) begin
            send_item(field_buf[k], vary ? 6'($urandom_range(0, 63)) : tv,
                      k == field_buf.size() - 1);
        end
        field_buf.delete();
    endtask

    // Hold off the sender until every predicted result has been returned.
    // The first edge lets the checker count the field just sent.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    task automatic load_text(input string txt);
        int k;
        for (k = 0; k < txt.len(); k++) field_buf.push_back(txt[k]);
    endtask

    // An odd character now and then, anywhere in a field. Most are ignored by
    // the block; an ignored one inside a number must not split it.
    task automatic sprinkle_noise();
        if ($urandom_range(0, 19) == 0) field_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic append_number(input int unsigned value);
        logic [CH_W-1:0] digits [$];
        int unsigned     rest;
        int              k;
        // A leading zero exercises accumulation over more digits.
        if ($urandom_range(0, 9) == 0) field_buf.push_back(CH_ZERO);
        rest = value;
        do begin
            digits.push_front(CH_ZERO + 8'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        for (k = 0; k < digits.size(); k++) begin
            if (k > 0) sprinkle_noise();
            field_buf.push_back(digits[k]);
        end
    endtask

    // Numbers cluster around the time value so that terms hit often; a few
    // are beyond the stored width to exercise saturation.
    function automatic int unsigned pick_value(input logic [TIME_W-1:0] tv);
        int roll;
        int near;
        roll = $urandom_range(0, 99);
        if (roll < 40) return tv;
        if (roll < 70) begin
            near = int'(tv) + $urandom_range(0, 6) - 3;
            return (near < 0) ? 0 : near;
        end
        if (roll < 90) return $urandom_range(0, 63);
        return $urandom_range(64, 999);
    endfunction

    function automatic int unsigned pick_step(input logic [TIME_W-1:0] tv);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 0;
        if (roll < 30) return int'(tv) + 1;
        if (roll < 75) return $urandom_range(1, 8);
        return $urandom_range(1, 70);
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic add_random_term(input logic [TIME_W-1:0] tv);
        int          roll;
        int unsigned lo;
        int unsigned hi;
        int unsigned spare;
        int          k;
        term_kind_t  kind;
        roll = $urandom_range(0, 99);
        if (roll < 20)      kind = TERM_NUMBER;
        else if (roll < 30) kind = TERM_STAR;
        else if (roll < 50) kind = TERM_RANGE;
        else if (roll < 65) kind = TERM_STEP;
        else if (roll < 87) kind = TERM_RANGE_STEP;
        else                kind = TERM_BROKEN;

        lo = $urandom_range(0, tv);
        hi = $urandom_range(tv, 63);
        // Now and then the bounds come in any order, or miss the value.
        if ($urandom_range(0, 4) == 0) begin
            lo = pick_value(tv);
            hi = pick_value(tv);
        end
        if ($urandom_range(0, 9) == 0) begin
            spare = lo;
            lo    = hi;
            hi    = spare;
        end

        sprinkle_noise();
        case (kind)
            TERM_NUMBER: begin
                append_number(pick_value(tv));
            end
            TERM_STAR: begin
                field_buf.push_back(CH_STAR);
            end
            TERM_RANGE: begin
                append_number(lo);
                sprinkle_noise();
                field_buf.push_back(CH_DASH);
                append_number(hi);
            end
            TERM_STEP: begin
                field_buf.push_back(CH_STAR);
                field_buf.push_back(CH_SLASH);
                append_number(pick_step(tv));
            end
            TERM_RANGE_STEP: begin
                append_number(lo);
                field_buf.push_back(CH_DASH);
                append_number(hi);
                sprinkle_noise();
                field_buf.push_back(CH_SLASH);
                append_number(pick_step(tv));
            end
            default: begin
                // Broken term: a short jumble of digits, separators and bytes.
                for (k = 0; k < $urandom_range(1, 5); k++) begin
                    case ($urandom_range(0, 4))
                        0: field_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                        1: field_buf.push_back(CH_STAR);
                        2: field_buf.push_back(CH_DASH);
                        3: field_buf.push_back(CH_SLASH);
                        default: field_buf.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        endcase
        sprinkle_noise();
    endtask

    initial begin
        int               directed_items;
        int               field_idx;
        int               terms;
        int               j;
        logic [TIME_W-1:0] tv;

        // Synchronous reset, held low from time zero and released once.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed fields.
        load_text("*");       send_field(6'd0, 1'b0);   // a bare star matches
        load_text("63");      send_field(6'd63, 1'b0);  // largest time value
        load_text("1-10");    send_field(6'd10, 1'b0);  // upper range bound
        load_text("*/0");     send_field(6'd5, 1'b0);   // a zero step never matches
        load_text("2-20/3");  send_field(6'd4, 1'b0);   // stepped range hit
        load_text("7,999");   send_field(6'd7, 1'b0);   // second number saturates
        load_text("5/2");     send_field(6'd5, 1'b0);   // slash without a star
        // Ignored bytes at both ends of the byte range, then a comma that is
        // also the last character, in a field with no number at all.
        field_buf.push_back(8'h00);
        field_buf.push_back(8'hFF);
        field_buf.push_back(CH_COMMA);
        send_field(6'd0, 1'b0);
        drain_results();
        directed_items = items_sent;

        // Random fields of one to four terms. Every 64 fields a stretch of
        // 16 runs with no idling on either side.
        field_idx = 0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            quiet <= ((field_idx % 64) >= 48);
            tv    = pick_time();
            terms = $urandom_range(1, 4);
            for (j = 0; j < terms; j++) begin
                if (j > 0) field_buf.push_back(CH_COMMA);
                add_random_term(tv);
            end
            if ($urandom_range(0, 9) == 0) field_buf.push_back(CH_COMMA);
            send_field(tv, $urandom_range(0, 9) == 0);
            if (field_idx % 50 == 49) drain_results();
            field_idx++;
        end

        // Let every outstanding result come back, then a few more cycles to
        // catch any stray result transaction.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
